>>> hdl/burner_status_frame_parser_top_assert.svh
// assertion macros for the burner status frame parser
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef BURNER_STATUS_FRAME_PARSER_TOP_ASSERT_SVH
`define BURNER_STATUS_FRAME_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define BSFP_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSFP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bsfp_pkg.sv
// ----------------------------------------------------------------------------
// bsfp_pkg
// Shared types and constants of the burner status frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsfp_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_END_BYTE   = 2'd1,
    CFG_MAX_TEMP   = 2'd2
  } cfg_idx_e;

  // result source format codes
  typedef enum logic [1:0] {
    FMT_NONE   = 2'd0,
    FMT_BINARY = 2'd1,
    FMT_TEXT   = 2'd2
  } src_fmt_e;

  // reset values of the configuration registers
  localparam logic [7:0]  RESET_START_BYTE = 8'hAA;
  localparam logic [7:0]  RESET_END_BYTE   = 8'h55;
  localparam logic [15:0] RESET_MAX_TEMP   = 16'd1000;

  // buffer length limits for a text line
  localparam logic [7:0]  MIN_TEXT_LEN = 8'd10;
  localparam logic [7:0]  MAX_TEXT_LEN = 8'd64;
  localparam logic [7:0]  COUNT_MAX    = 8'd255;

  // bytes held ahead of the closing byte of a binary frame
  localparam logic [7:0]  FRAME_PRE_BYTES = 8'd5;

  // fan clamp and number saturation
  localparam logic [6:0]  FAN_MAX = 7'd100;
  localparam logic [16:0] NUM_SAT = 17'h1FFFF;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register set
  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [15:0] max_temp;
  } cfg_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last_byte;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_ws;
    logic       is_plus;
    logic       is_minus;
    logic       is_comma;
    logic       is_colon;
    logic       is_f;
    logic       is_s;
    logic       is_t;
    logic       is_nul;
    logic       is_end;
  } byte_class_t;

  // one result item
  typedef struct packed {
    logic        valid_res;
    logic [1:0]  source_format;
    logic        flame_seen;
    logic [6:0]  fan_pct;
    logic [15:0] temperature;
    logic [6:0]  fault_flags;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/bsfp_if.sv
// ----------------------------------------------------------------------------
// bsfp_if
// Valid/ready channels for the byte input and the status result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// byte input channel
interface bsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// status result channel
interface bsfp_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [1:0]  source_format;
  logic        flame_seen;
  logic [6:0]  fan_pct;
  logic [15:0] temperature;
  logic [6:0]  fault_flags;

  modport source (output valid, output valid_res, output source_format,
                  output flame_seen, output fan_pct, output temperature,
                  output fault_flags, input ready);
  modport sink   (input valid, input valid_res, input source_format,
                  input flame_seen, input fan_pct, input temperature,
                  input fault_flags, output ready);
endinterface

`default_nettype wire

>>> hdl/bsfp_front.sv
// ----------------------------------------------------------------------------
// bsfp_front
// Accepts raw bytes and classifies them for the parser back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsfp_front (
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              data_byte_i,
  input  logic                    last_byte_i,
  input  logic [7:0]              end_byte_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output bsfp_pkg::byte_class_t   q_item_o
);

  // handshake: accept whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // character classification
  always_comb begin
    q_item_o           = '0;
    q_item_o.data      = data_byte_i;
    q_item_o.last_byte = last_byte_i;
    q_item_o.is_digit  = (data_byte_i >= 8'h30) && (data_byte_i <= 8'h39);
    q_item_o.digit     = data_byte_i[3:0];
    q_item_o.is_ws     = (data_byte_i == 8'h20) ||
                         ((data_byte_i >= 8'h09) && (data_byte_i <= 8'h0D));
    q_item_o.is_plus   = (data_byte_i == 8'h2B);
    q_item_o.is_minus  = (data_byte_i == 8'h2D);
    q_item_o.is_comma  = (data_byte_i == 8'h2C);
    q_item_o.is_colon  = (data_byte_i == 8'h3A);
    q_item_o.is_f      = (data_byte_i == 8'h46);
    q_item_o.is_s      = (data_byte_i == 8'h53);
    q_item_o.is_t      = (data_byte_i == 8'h54);
    q_item_o.is_nul    = (data_byte_i == 8'h00);
    q_item_o.is_end    = (data_byte_i == end_byte_i);
  end

endmodule

`default_nettype wire

>>> hdl/bsfp_queue.sv
// ----------------------------------------------------------------------------
// bsfp_queue
// Short register queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsfp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bsfp_pkg::byte_class_t item_i,
  output logic                  full_o,
  output logic                  valid_o,
  output bsfp_pkg::byte_class_t item_o,
  input  logic                  pop_i
);

  localparam int unsigned Depth  = bsfp_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0]   LastPtr   = PtrW'(Depth - 1);
  localparam logic [CountW-1:0] FullCount = CountW'(Depth);

  bsfp_pkg::byte_class_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == FullCount);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CountW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bsfp_back.sv
// ----------------------------------------------------------------------------
// bsfp_back
// Binary window search, text line parser and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsfp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bsfp_pkg::cfg_t        cfg_i,
  input  logic                  q_valid_i,
  input  bsfp_pkg::byte_class_t q_item_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bsfp_pkg::result_t     out_res_o
);

  typedef enum logic [4:0] {
    PH_F, PH_F_COLON, PH_N1, PH_N1_SIGN, PH_N1D,
    PH_S, PH_S_COLON, PH_N2, PH_N2_SIGN, PH_N2D,
    PH_T, PH_T_COLON, PH_N3, PH_N3_SIGN, PH_N3D,
    PH_DONE, PH_FAIL
  } phase_e;

  typedef struct packed {
    logic        flame;
    logic [6:0]  fan;
    logic [15:0] temp;
    logic [6:0]  err;
  } frame_t;

  // number start state after the colon
  function automatic phase_e after_colon(input phase_e p);
    phase_e r;
    unique case (p)
      PH_F_COLON: r = PH_N1;
      PH_S_COLON: r = PH_N2;
      default:    r = PH_N3;
    endcase
    return r;
  endfunction

  // state after a sign at number start
  function automatic phase_e after_sign(input phase_e p);
    phase_e r;
    unique case (p)
      PH_N1:   r = PH_N1_SIGN;
      PH_N2:   r = PH_N2_SIGN;
      default: r = PH_N3_SIGN;
    endcase
    return r;
  endfunction

  // digit-run state of the current number
  function automatic phase_e digit_run(input phase_e p);
    phase_e r;
    unique case (p)
      PH_N1, PH_N1_SIGN: r = PH_N1D;
      PH_N2, PH_N2_SIGN: r = PH_N2D;
      default:           r = PH_N3D;
    endcase
    return r;
  endfunction

  phase_e            phase_q, phase_d, phase_fin;
  logic [4:0][7:0]   recent_q, recent_d;
  logic [7:0]        count_q, count_d;
  logic              found_q, found_d;
  frame_t            frame_q, frame_d;
  logic [2:0]        letters_q, letters_d;
  logic              neg_q, neg_d;
  logic [16:0]       val_q, val_d;
  logic              tflame_q, tflame_d;
  logic [6:0]        tfan_q, tfan_d;
  logic              ended_q, ended_d;
  logic              out_valid_q, out_valid_d;
  bsfp_pkg::result_t out_q, out_d;

  logic              out_free, take;
  logic [15:0]       win_temp;
  logic [20:0]       acc;
  logic              text_ok;

  assign out_free    = !out_valid_q || out_ready_i;
  assign take        = q_valid_i && (!q_item_i.last_byte || out_free);
  assign q_pop_o     = take;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // window temperature and decimal accumulate
  assign win_temp = {recent_q[1], recent_q[0]};
  assign acc      = {1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0} + {17'd0, q_item_i.digit};

  always_comb begin
    phase_d     = phase_q;
    recent_d    = recent_q;
    count_d     = count_q;
    found_d     = found_q;
    frame_d     = frame_q;
    letters_d   = letters_q;
    neg_d       = neg_q;
    val_d       = val_q;
    tflame_d    = tflame_q;
    tfan_d      = tfan_q;
    ended_d     = ended_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    phase_fin   = phase_q;
    text_ok     = 1'b0;

    // result taken by the receiver
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (take) begin
      // binary window closing at this byte
      if (!found_q && (count_q >= bsfp_pkg::FRAME_PRE_BYTES) &&
          (recent_q[4] == cfg_i.start_byte) && q_item_i.is_end &&
          (win_temp <= cfg_i.max_temp)) begin
        found_d       = 1'b1;
        frame_d.flame = recent_q[3][0];
        frame_d.err   = recent_q[3][7:1];
        frame_d.fan   = (recent_q[2] > {1'b0, bsfp_pkg::FAN_MAX}) ?
                        bsfp_pkg::FAN_MAX : recent_q[2][6:0];
        frame_d.temp  = win_temp;
      end

      // text line grammar
      if (!ended_q && (phase_q != PH_DONE) && (phase_q != PH_FAIL)) begin
        if (q_item_i.is_nul) begin
          ended_d = 1'b1;
          phase_d = (phase_q == PH_N3D) ? PH_DONE : PH_FAIL;
        end else begin
          unique case (phase_q)
            PH_F: phase_d = q_item_i.is_f ? PH_F_COLON : PH_FAIL;
            PH_S: phase_d = q_item_i.is_s ? PH_S_COLON : PH_FAIL;
            PH_T: phase_d = q_item_i.is_t ? PH_T_COLON : PH_FAIL;
            PH_F_COLON, PH_S_COLON, PH_T_COLON: begin
              phase_d = q_item_i.is_colon ? after_colon(phase_q) : PH_FAIL;
            end
            PH_N1, PH_N2, PH_N3: begin
              if (q_item_i.is_ws) begin
                phase_d = phase_q;
              end else if (q_item_i.is_plus || q_item_i.is_minus) begin
                neg_d   = q_item_i.is_minus;
                val_d   = '0;
                phase_d = after_sign(phase_q);
              end else if (q_item_i.is_digit) begin
                neg_d   = 1'b0;
                val_d   = {13'd0, q_item_i.digit};
                phase_d = digit_run(phase_q);
              end else begin
                phase_d = PH_FAIL;
              end
            end
            PH_N1_SIGN, PH_N2_SIGN, PH_N3_SIGN: begin
              if (q_item_i.is_digit) begin
                val_d   = {13'd0, q_item_i.digit};
                phase_d = digit_run(phase_q);
              end else begin
                phase_d = PH_FAIL;
              end
            end
            PH_N1D: begin
              if (q_item_i.is_digit) begin
                val_d = (acc[20:17] != '0) ? bsfp_pkg::NUM_SAT : acc[16:0];
              end else begin
                tflame_d = (val_q != '0);
                phase_d  = q_item_i.is_comma ? PH_S : PH_FAIL;
              end
            end
            PH_N2D: begin
              if (q_item_i.is_digit) begin
                val_d = (acc[20:17] != '0) ? bsfp_pkg::NUM_SAT : acc[16:0];
              end else begin
                if (neg_q) begin
                  tfan_d = '0;
                end else if (val_q > {10'd0, bsfp_pkg::FAN_MAX}) begin
                  tfan_d = bsfp_pkg::FAN_MAX;
                end else begin
                  tfan_d = val_q[6:0];
                end
                phase_d = q_item_i.is_comma ? PH_T : PH_FAIL;
              end
            end
            PH_N3D: begin
              if (q_item_i.is_digit) begin
                val_d = (acc[20:17] != '0) ? bsfp_pkg::NUM_SAT : acc[16:0];
              end else begin
                phase_d = PH_DONE;
              end
            end
            default: phase_d = phase_q;
          endcase
        end
      end

      // letters, length and byte history
      letters_d = letters_q | {q_item_i.is_t, q_item_i.is_s, q_item_i.is_f};
      count_d   = (count_q == bsfp_pkg::COUNT_MAX) ? count_q : count_q + 8'd1;
      recent_d  = {recent_q[3:0], q_item_i.data};

      // buffer close: build the result and clear per-buffer state
      if (q_item_i.last_byte) begin
        phase_fin = (phase_d == PH_N3D) ? PH_DONE : phase_d;
        text_ok   = (phase_fin == PH_DONE) &&
                    (count_d >= bsfp_pkg::MIN_TEXT_LEN) &&
                    (count_d < bsfp_pkg::MAX_TEXT_LEN) &&
                    (letters_d == 3'b111) &&
                    !(neg_d && (val_d != '0)) &&
                    (val_d <= {1'b0, cfg_i.max_temp});
        out_d = '0;
        if (found_d) begin
          out_d.valid_res     = 1'b1;
          out_d.source_format = bsfp_pkg::FMT_BINARY;
          out_d.flame_seen    = frame_d.flame;
          out_d.fan_pct       = frame_d.fan;
          out_d.temperature   = frame_d.temp;
          out_d.fault_flags   = frame_d.err;
        end else if (text_ok) begin
          out_d.valid_res     = 1'b1;
          out_d.source_format = bsfp_pkg::FMT_TEXT;
          out_d.flame_seen    = tflame_d;
          out_d.fan_pct       = tfan_d;
          out_d.temperature   = val_d[15:0];
        end
        out_valid_d = 1'b1;

        phase_d   = PH_F;
        recent_d  = '0;
        count_d   = '0;
        found_d   = 1'b0;
        frame_d   = '0;
        letters_d = '0;
        neg_d     = 1'b0;
        val_d     = '0;
        tflame_d  = 1'b0;
        tfan_d    = '0;
        ended_d   = 1'b0;
      end
    end
  end

  // parser state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_F;
      recent_q    <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      frame_q     <= '0;
      letters_q   <= '0;
      neg_q       <= 1'b0;
      val_q       <= '0;
      tflame_q    <= 1'b0;
      tfan_q      <= '0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      recent_q    <= recent_d;
      count_q     <= count_d;
      found_q     <= found_d;
      frame_q     <= frame_d;
      letters_q   <= letters_d;
      neg_q       <= neg_d;
      val_q       <= val_d;
      tflame_q    <= tflame_d;
      tfan_q      <= tfan_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/burner_status_frame_parser_top.sv
// ----------------------------------------------------------------------------
// burner_status_frame_parser_top
// Burner status parser: binary frame search with text line fallback.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one byte of a received buffer per item; last_byte marks
//   the final byte. Every buffer gives exactly one item on out_ch when its
//   last byte has gone through: valid_res is 1 with a binary (format 1) or
//   text (format 2) status, otherwise all result fields are zero.
//   Configuration registers (start marker, end marker, temperature limit)
//   are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must
//   do so only while idle, the block itself does not enforce it.
// Throughput: one byte per cycle unless the queue is full or a last byte
//   waits for a free result register; the back end updates all parser
//   state in a single step. Result path: the last byte passes the queue,
//   then the back end loads the result register, held there until taken.
// Reset: configuration returns to 0xAA / 0x55 / 1000, the queue empties
//   and all per-buffer state clears.
// Stall: the result register holds while out_ch.ready is low; the back end
//   keeps consuming bytes until the next last byte, then the queue fills
//   and in_ch.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "burner_status_frame_parser_top_assert.svh"

module burner_status_frame_parser_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  bsfp_in_if.sink            in_ch,
  bsfp_out_if.source         out_ch,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);

  bsfp_pkg::cfg_t        cfg_q;
  bsfp_pkg::byte_class_t push_item, q_item;
  bsfp_pkg::result_t     res;
  logic                  q_full, q_push, q_valid, q_pop;
  logic                  in_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte <= bsfp_pkg::RESET_START_BYTE;
      cfg_q.end_byte   <= bsfp_pkg::RESET_END_BYTE;
      cfg_q.max_temp   <= bsfp_pkg::RESET_MAX_TEMP;
    end else if (cfg_we_i) begin
      unique case (bsfp_pkg::cfg_idx_e'(cfg_idx_i))
        bsfp_pkg::CFG_START_BYTE: cfg_q.start_byte <= cfg_wdata_i[7:0];
        bsfp_pkg::CFG_END_BYTE:   cfg_q.end_byte   <= cfg_wdata_i[7:0];
        bsfp_pkg::CFG_MAX_TEMP:   cfg_q.max_temp   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front end: accept and classify
  bsfp_front u_front (
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ready),
    .data_byte_i (in_ch.data_byte),
    .last_byte_i (in_ch.last_byte),
    .end_byte_i  (cfg_q.end_byte),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (push_item)
  );

  assign in_ch.ready = in_ready;

  // queue between front and back
  bsfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  // back end: parse and hold the result
  bsfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_res_o   (res)
  );

  assign out_ch.valid_res     = res.valid_res;
  assign out_ch.source_format = res.source_format;
  assign out_ch.flame_seen    = res.flame_seen;
  assign out_ch.fan_pct       = res.fan_pct;
  assign out_ch.temperature   = res.temperature;
  assign out_ch.fault_flags   = res.fault_flags;

  // checks
  `BSFP_ASSERT_NEXT(a_last_gives_result, q_pop && q_item.last_byte, out_ch.valid,
    "closing byte did not load a result")
  `BSFP_ASSERT_IMPLIES(a_empty_result_zero, out_ch.valid && !out_ch.valid_res,
    (out_ch.source_format == bsfp_pkg::FMT_NONE) && (out_ch.fan_pct == '0) &&
    (out_ch.temperature == '0) && (out_ch.fault_flags == '0) && !out_ch.flame_seen,
    "empty result carries nonzero fields")
  `BSFP_ASSERT_IMPLIES(a_result_in_range, out_ch.valid && out_ch.valid_res,
    (out_ch.temperature <= cfg_q.max_temp) && (out_ch.fan_pct <= bsfp_pkg::FAN_MAX),
    "result temperature or fan out of range")
  `BSFP_ASSERT_IMPLIES(a_text_no_error, out_ch.valid && out_ch.valid_res &&
    (out_ch.source_format == bsfp_pkg::FMT_TEXT), out_ch.fault_flags == '0,
    "text result carries an error code")

endmodule

`default_nettype wire
